// ----- hdl/rse_pkg.sv -----
// Shared constants and types for the running standard deviation estimator.
package rse_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;

  localparam int LIMIT_W = 16;
  localparam int MEAN_W  = 32;
  localparam int STD_W   = 24;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = 64;

  localparam int SQ_W    = SAMPLE_WIDTH + FRAC_W;
  localparam int WIDE_W  = (SQ_W > MEAN_W) ? SQ_W : MEAN_W;
  localparam int DELTA_W = WIDE_W + 1;
  localparam int MAG_W   = DELTA_W;
  localparam int NM_W    = DELTA_W + 1;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int INC_W   = PROD_W - FRAC_W;
  localparam int ACC_W   = ((INC_W > SUM_W) ? INC_W : SUM_W) + 1;
  localparam int CMP_W   = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  localparam int DIV_W      = SUM_W;
  localparam int DIV_STEP_W = $clog2(DIV_W / 2 + 1);
  localparam int MEAN_STEPS = (MAG_W + 1) / 2;
  localparam int VAR_STEPS  = DIV_W / 2;
  localparam int MEAN_ALIGN = DIV_W - 2 * MEAN_STEPS;

  localparam int MUL_CNT_W  = $clog2(MAG_W + 1);
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

  localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_BITS    = MEAN_W + STD_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;

  localparam logic [ADDR_W-3:0]  REG_SAMPLE_LIMIT = '0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET      = LIMIT_W'(100);

  localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_DIV,
    ST_MEAN_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_VAR_DIV,
    ST_VAR_WAIT,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_WRITE
  } state_t;

endpackage

// ----- hdl/rse_div.sv -----
// Radix-4 restoring divider by the sample count, two quotient bits per cycle.
module rse_div
  import rse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DIV_W-1:0]       dividend,
  input  logic [COUNT_WIDTH-1:0] divisor,
  input  logic [DIV_STEP_W-1:0]  steps,
  output logic [DIV_W-1:0]       quotient,
  output logic                   done
);

  logic [DIV_W-1:0]       quo;
  logic [DIV_W-1:0]       quo_next;
  logic [COUNT_WIDTH-1:0] rem;
  logic [COUNT_WIDTH-1:0] rem_mid;
  logic [COUNT_WIDTH-1:0] rem_next;
  logic [COUNT_WIDTH-1:0] den;
  logic [COUNT_WIDTH:0]   r1;
  logic [COUNT_WIDTH:0]   r2;
  logic                   ge1;
  logic                   ge2;
  logic [DIV_STEP_W-1:0]  cnt;
  logic                   busy;

  always_comb begin
    r1       = {rem, quo[DIV_W-1]};
    ge1      = r1 >= {1'b0, den};
    rem_mid  = ge1 ? COUNT_WIDTH'(r1 - {1'b0, den}) : COUNT_WIDTH'(r1);
    r2       = {rem_mid, quo[DIV_W-2]};
    ge2      = r2 >= {1'b0, den};
    rem_next = ge2 ? COUNT_WIDTH'(r2 - {1'b0, den}) : COUNT_WIDTH'(r2);
    quo_next = {quo[DIV_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ----- hdl/rse_mul.sv -----
// Bit-serial shift-add multiplier for the deviation product.
module rse_mul
  import rse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  a,
  input  logic [MAG_W-1:0]  b,
  output logic [PROD_W-1:0] product,
  output logic              done
);

  logic [PROD_W-1:0]    prod;
  logic [MAG_W-1:0]     mcand;
  logic [MAG_W:0]       upper;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;

  always_comb begin
    upper = {1'b0, prod[PROD_W-1:MAG_W]} + (prod[0] ? {1'b0, mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= {{MAG_W{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      prod <= {upper, prod[MAG_W-1:1]};
    end
  end

  assign product = prod;

endmodule

// ----- hdl/rse_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
module rse_sqrt
  import rse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [SUM_W-1:0]      x;
  logic [ROOT_W-1:0]     rt;
  logic [ROOT_W+1:0]     rem;
  logic [ROOT_W+3:0]     shifted;
  logic [ROOT_W+3:0]     trial;
  logic                  ge;
  logic [ROOT_W+1:0]     rem_next;
  logic [SQRT_CNT_W-1:0] cnt;
  logic                  busy;

  always_comb begin
    shifted  = {rem, x[SUM_W-1:SUM_W-2]};
    trial    = (ROOT_W+4)'({rt, 2'b01});
    ge       = shifted >= trial;
    rem_next = ge ? (ROOT_W+2)'(shifted - trial) : (ROOT_W+2)'(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SQRT_CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == SQRT_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= radicand;
      rt  <= '0;
      rem <= '0;
    end else if (busy) begin
      x   <= {x[SUM_W-3:0], 2'b00};
      rt  <= {rt[ROOT_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign root = rt;

endmodule

// ----- hdl/running_stddev_estimator_top.sv -----
// Welford running mean and population standard deviation over a sample stream.
//
// Each sample word yields one result word carrying the running mean (Q16.16),
// the population standard deviation (Q16.8) and the done flag. A sample passes
// through the radix-4 divider for the mean step, the bit-serial multiplier,
// the divider for the variance and the square root unit. Once the sample count
// reaches sample_limit the statistics freeze and each further sample is
// answered with the frozen values. A new sample is taken while the previous
// result still waits in the output register. sample_limit lies at byte
// address 0 and should be written only while the block is idle.
module running_stddev_estimator_top
  import rse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // sample [15:0]
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // mean_value [31:0], std_dev [55:32], estimation_done [56], zero fill above
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  state_t state;
  state_t state_next;

  logic [LIMIT_W-1:0]        sample_limit;
  logic [COUNT_WIDTH-1:0]    sample_count;
  logic signed [MEAN_W-1:0]  running_mean;
  logic [SUM_W-1:0]          sq_dev_sum;
  logic [STD_W-1:0]          dev_estimate;
  logic                      done_flag;

  logic signed [SQ_W-1:0]    sq;
  logic [MAG_W-1:0]          delta_mag;
  logic                      delta_neg;
  logic                      delta_pos;
  logic                      kill;

  logic signed [MEAN_W-1:0]  out_mean;
  logic [STD_W-1:0]          out_std;
  logic                      out_done;

  logic                      in_acc;
  logic                      out_free;
  logic                      reg_hit;
  logic                      div_start;
  logic                      div_var;
  logic                      mul_start;
  logic                      sqrt_start;

  logic signed [DELTA_W-1:0] delta;
  logic [MAG_W-1:0]          delta_mag_c;
  logic signed [DELTA_W-1:0] err;
  logic [MAG_W-1:0]          err_mag;
  logic signed [NM_W-1:0]    mean_ext;
  logic signed [NM_W-1:0]    qm_s;
  logic signed [NM_W-1:0]    nm;
  logic signed [MEAN_W-1:0]  nm_sat;
  logic [INC_W-1:0]          inc;
  logic [ACC_W-1:0]          acc;
  logic [SUM_W-1:0]          sum_sat;
  logic [STD_W-1:0]          std_sat;
  logic                      limit_hit;

  logic [DIV_W-1:0]          div_dividend;
  logic [DIV_STEP_W-1:0]     div_steps;
  logic [DIV_W-1:0]          div_q;
  logic                      div_done;
  logic [PROD_W-1:0]         mul_p;
  logic                      mul_done;
  logic [ROOT_W-1:0]         sqrt_root;
  logic                      sqrt_done;

  rse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sample_count),
    .steps    (div_steps),
    .quotient (div_q),
    .done     (div_done)
  );

  rse_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (delta_mag),
    .b       (err_mag),
    .product (mul_p),
    .done    (mul_done)
  );

  rse_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (div_q),
    .root     (sqrt_root),
    .done     (sqrt_done)
  );

  // datapath arithmetic
  always_comb begin
    delta       = DELTA_W'(sq) - DELTA_W'(running_mean);
    delta_mag_c = delta[DELTA_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
    err         = DELTA_W'(sq) - DELTA_W'(running_mean);
    err_mag     = err[DELTA_W-1] ? MAG_W'(-err) : MAG_W'(err);

    mean_ext = NM_W'(running_mean);
    qm_s     = signed'(NM_W'(div_q[MAG_W-1:0]));
    nm       = delta_neg ? mean_ext - qm_s : mean_ext + qm_s;
    if (nm > NM_W'(MEAN_MAX)) begin
      nm_sat = MEAN_MAX;
    end else if (nm < NM_W'(MEAN_MIN)) begin
      nm_sat = MEAN_MIN;
    end else begin
      nm_sat = MEAN_W'(nm);
    end

    inc     = kill ? '0 : mul_p[PROD_W-1:FRAC_W];
    acc     = ACC_W'(sq_dev_sum) + ACC_W'(inc);
    sum_sat = (acc[ACC_W-1:SUM_W] != '0) ? '1 : acc[SUM_W-1:0];

    std_sat   = (sqrt_root[ROOT_W-1:STD_W] != '0) ? '1 : sqrt_root[STD_W-1:0];
    limit_hit = CMP_W'(sample_count) >= CMP_W'(sample_limit);

    div_dividend = div_var ? sq_dev_sum : DIV_W'(delta_mag_c) << MEAN_ALIGN;
    div_steps    = div_var ? DIV_STEP_W'(VAR_STEPS) : DIV_STEP_W'(MEAN_STEPS);
  end

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = done_flag ? ST_WRITE : ST_MEAN_DIV;
        end
      end
      ST_MEAN_DIV:  state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_done) state_next = ST_MUL;
      ST_MUL:       state_next = ST_MUL_WAIT;
      ST_MUL_WAIT:  if (mul_done) state_next = ST_VAR_DIV;
      ST_VAR_DIV:   state_next = ST_VAR_WAIT;
      ST_VAR_WAIT:  if (div_done) state_next = ST_SQRT;
      ST_SQRT:      state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_done) state_next = ST_WRITE;
      ST_WRITE:     if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready   = 1'b0;
    div_start  = 1'b0;
    div_var    = 1'b0;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    unique case (state)
      ST_IDLE:     s_tready = 1'b1;
      ST_MEAN_DIV: div_start = 1'b1;
      ST_MUL:      mul_start = 1'b1;
      ST_VAR_DIV: begin
        div_start = 1'b1;
        div_var   = 1'b1;
      end
      ST_SQRT:     sqrt_start = 1'b1;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      running_mean <= '0;
      sq_dev_sum   <= '0;
      dev_estimate <= '0;
      done_flag    <= 1'b0;
    end else begin
      if (in_acc && !done_flag && sample_count != '1) begin
        sample_count <= sample_count + 1'b1;
      end
      if (state == ST_MEAN_WAIT && div_done) begin
        running_mean <= nm_sat;
      end
      if (state == ST_MUL_WAIT && mul_done) begin
        sq_dev_sum <= sum_sat;
      end
      if (state == ST_SQRT_WAIT && sqrt_done) begin
        dev_estimate <= std_sat;
        done_flag    <= limit_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq <= {s_tdata[SAMPLE_WIDTH-1:0], {FRAC_W{1'b0}}};
    end
    if (state == ST_MEAN_DIV) begin
      delta_mag <= delta_mag_c;
      delta_neg <= delta[DELTA_W-1];
      delta_pos <= !delta[DELTA_W-1] && (delta != '0);
    end
    if (state == ST_MUL) begin
      kill <= (delta_neg && !err[DELTA_W-1] && err != '0) ||
              (delta_pos && err[DELTA_W-1]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      out_mean <= running_mean;
      out_std  <= dev_estimate;
      out_done <= done_flag;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_done, out_std, out_mean});

  // config port
  assign reg_hit = paddr[ADDR_W-1:2] == REG_SAMPLE_LIMIT;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(sample_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sample_limit <= pwdata[LIMIT_W-1:0];
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the running standard deviation estimator.
module tb;
  import rse_pkg::*;

  typedef struct packed {
    logic                     done;
    logic [STD_W-1:0]         sd;
    logic signed [MEAN_W-1:0] mean;
  } stats_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [LIMIT_W-1:0] data;
    logic               typed;
    stats_t             want;
  } stim_row_t;

  localparam logic [ADDR_W-1:0] ADDR_SAMPLE_LIMIT = {REG_SAMPLE_LIMIT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED     = {~REG_SAMPLE_LIMIT, 2'b00};

  localparam int HEAD_ROWS   = 15;
  localparam int PLAN_ROWS   = 22;
  localparam int RAND_A      = 950;
  localparam int RAND_TOTAL  = 1930;
  localparam int QUIET_FROM  = 1780;
  localparam int LONG_HOLD   = 600;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_WAIT   = 300;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // sample [15:0]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // mean_value [31:0], std_dev [55:32], estimation_done [56]
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // estimator state as predicted
  logic [COUNT_WIDTH-1:0] n_seen;
  longint                 mean_acc;
  logic [SUM_W-1:0]       dev_sum;
  logic [STD_W-1:0]       sd_now;
  bit                     frozen;
  logic [LIMIT_W-1:0]     limit_now;

  stats_t stats_q [$];
  stats_t got_now;
  stats_t want_now;
  int     error_count;
  bit     quiet_tail;
  bit     hold_req;
  int     hold_left;

  stim_row_t plan [PLAN_ROWS] = '{
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h0000, 1'b1, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h0000, 1'b1, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h7FFF, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h8000, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h8000, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h7FFF, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h0001, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h5555, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'hAAAA, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h00FF, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'hFF00, 1'b0, '0},
    '{ROW_WRITE,  ADDR_UNMAPPED,     16'h0001, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h0100, 1'b0, '0},
    '{ROW_WRITE,  ADDR_SAMPLE_LIMIT, 16'hFFFF, 1'b0, '0},
    // tail: limit below the count, then zero; statistics freeze
    '{ROW_WRITE,  ADDR_SAMPLE_LIMIT, 16'h0001, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h1234, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h7FFF, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h8000, 1'b0, '0},
    '{ROW_WRITE,  ADDR_SAMPLE_LIMIT, 16'h0000, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'h0000, 1'b0, '0},
    '{ROW_SAMPLE, ADDR_SAMPLE_LIMIT, 16'hFFFF, 1'b0, '0}
  };

  running_stddev_estimator_top uut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic stats_t welford_step(input logic signed [SAMPLE_WIDTH-1:0] smp);
    longint        scaled;
    longint        delta;
    longint        err;
    longint        nm;
    logic [63:0]   dmag;
    logic [63:0]   emag;
    logic [63:0]   qmag;
    logic [63:0]   inc;
    logic [63:0]   var_q;
    logic [63:0]   root;
    logic [63:0]   bitv;
    logic [127:0]  prod;
    logic [64:0]   acc;
    stats_t        r;
    if (!frozen) begin
      scaled = longint'(smp) * 65536;
      if (n_seen != '1)
        n_seen++;
      delta = scaled - mean_acc;
      dmag = (delta < 0) ? -delta : delta;
      qmag = dmag / 64'(n_seen);
      nm = (delta < 0) ? mean_acc - longint'(qmag) : mean_acc + longint'(qmag);
      if (nm > longint'(MEAN_MAX))
        nm = MEAN_MAX;
      if (nm < longint'(MEAN_MIN))
        nm = MEAN_MIN;
      mean_acc = nm;
      err = scaled - mean_acc;
      emag = (err < 0) ? -err : err;
      if ((delta < 0 && err > 0) || (delta > 0 && err < 0)) begin
        inc = '0;
      end else begin
        prod = ({64'b0, dmag} * {64'b0, emag}) >> FRAC_W;
        inc = (prod[127:64] != 0) ? '1 : prod[63:0];
      end
      acc = {1'b0, dev_sum} + {1'b0, inc};
      dev_sum = acc[64] ? '1 : acc[63:0];
      var_q = dev_sum / 64'(n_seen);
      // bitwise integer square root, floor
      root = '0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > var_q)
        bitv >>= 2;
      while (bitv != 0) begin
        if (var_q >= root + bitv) begin
          var_q -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      sd_now = (root > 64'hFF_FFFF) ? '1 : root[STD_W-1:0];
      if (n_seen >= limit_now)
        frozen = 1'b1;
    end
    r.mean = mean_acc[MEAN_W-1:0];
    r.sd   = sd_now;
    r.done = frozen;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 40)
      $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (stats_q.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [LIMIT_W-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_SAMPLE_LIMIT)
      limit_now = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= ADDR_SAMPLE_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(limit_now))
      report_mismatch("sample_limit readback", prdata, limit_now);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_sample(input logic [SAMPLE_WIDTH-1:0] smp, input logic typed,
                             input stats_t want);
    stats_t pred;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(smp);
    do @(posedge clk); while (!s_tready);
    pred = welford_step(smp);
    stats_q.push_back(typed ? want : pred);
  endtask

  task automatic run_row(input stim_row_t row);
    case (row.kind)
      ROW_WRITE:  write_reg(row.addr, row.data);
      ROW_SAMPLE: push_sample(row.data, row.typed, row.want);
    endcase
  endtask

  // result side
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (stats_q.size() == 0) begin
        report_mismatch("result word with nothing expected", m_tdata, 0);
      end else begin
        want_now = stats_q.pop_front();
        got_now = m_tdata[$bits(stats_t)-1:0];
        if (got_now.mean !== want_now.mean)
          report_mismatch("mean_value", got_now.mean, want_now.mean);
        if (got_now.sd !== want_now.sd)
          report_mismatch("std_dev", got_now.sd, want_now.sd);
        if (got_now.done !== want_now.done)
          report_mismatch("estimation_done", got_now.done, want_now.done);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int centre;
    int v;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    quiet_tail = 1'b0;
    error_count = 0;
    n_seen = '0;
    mean_acc = 0;
    dev_sum = '0;
    sd_now = '0;
    frozen = 1'b0;
    limit_now = LIMIT_RESET;
    centre = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < HEAD_ROWS; i++)
      run_row(plan[i]);

    // sensor-like noise around a drifting offset, with full-range words mixed in
    for (int i = 0; i < RAND_TOTAL; i++) begin
      if (i == 300)
        hold_req = 1'b1;
      if (i == 600)
        wait_idle();
      if (i == RAND_A)
        write_reg(ADDR_SAMPLE_LIMIT, 16'd3000);
      if (i == QUIET_FROM)
        quiet_tail = 1'b1;
      if (i % 100 == 0)
        centre = $urandom_range(0, 65535) - 32768;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: v = centre + $urandom_range(0, 64) - 32;
        6, 7:             v = $urandom_range(0, 65535);
        8:                v = $urandom_range(0, 1) ? 32'h7FFF : 32'h8000;
        default:          v = centre + $urandom_range(0, 8191) - 4096;
      endcase
      push_sample(v[SAMPLE_WIDTH-1:0], 1'b0, '0);
    end

    for (int i = HEAD_ROWS; i < PLAN_ROWS; i++)
      run_row(plan[i]);

    wait_idle();
    repeat (TAIL_WAIT) @(posedge clk);
    if (stats_q.size() != 0)
      report_mismatch("results never returned", stats_q.size(), 0);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rse_pkg.sv
hdl/rse_div.sv
hdl/rse_mul.sv
hdl/rse_sqrt.sv
hdl/running_stddev_estimator_top.sv
test/tb.sv
